>>> rtl/rrbb_pkg.sv
// ----------------------------------------------------------------------------
// Rotated rectangle bounding box: shared package
// Constants, widths and the Q8 cosine table used by the pipeline stages.
// ----------------------------------------------------------------------------
package rrbb_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int OUT_BITS       = 19;
	localparam int ANGLE_BITS     = 8;
	localparam int TRIG_BITS      = 10;
	localparam int Q8_SHIFT       = 8;
	localparam int QUARTER        = 64;

	localparam logic [8:0] QCOS [0:64] = '{
		9'd256, 9'd255, 9'd255, 9'd255, 9'd254, 9'd254, 9'd253, 9'd252, 9'd251, 9'd249,
		9'd248, 9'd246, 9'd244, 9'd243, 9'd241, 9'd238, 9'd236, 9'd234, 9'd231, 9'd228,
		9'd225, 9'd222, 9'd219, 9'd216, 9'd212, 9'd209, 9'd205, 9'd201, 9'd197, 9'd193,
		9'd189, 9'd185, 9'd181, 9'd176, 9'd171, 9'd167, 9'd162, 9'd157, 9'd152, 9'd147,
		9'd142, 9'd136, 9'd131, 9'd126, 9'd120, 9'd115, 9'd109, 9'd103, 9'd97,  9'd92,
		9'd86,  9'd80,  9'd74,  9'd68,  9'd62,  9'd56,  9'd49,  9'd43,  9'd37,  9'd31,
		9'd25,  9'd18,  9'd12,  9'd6,   9'd0
	};

	// The quarter-wave table is folded over the full turn by quadrant.
	function automatic logic signed [TRIG_BITS-1:0] cos_q8(input logic [ANGLE_BITS-1:0] a);
		logic [5:0]                  k;
		logic [6:0]                  kr;
		logic signed [TRIG_BITS-1:0] pos_k;
		logic signed [TRIG_BITS-1:0] pos_kr;
		logic signed [TRIG_BITS-1:0] res;
		k      = a[5:0];
		kr     = 7'(QUARTER) - {1'b0, k};
		pos_k  = TRIG_BITS'($signed({1'b0, QCOS[{1'b0, k}]}));
		pos_kr = TRIG_BITS'($signed({1'b0, QCOS[kr]}));
		case (a[7:6])
			2'd0: begin
				res = pos_k;
			end
			2'd1: begin
				res = -pos_kr;
			end
			2'd2: begin
				res = -pos_k;
			end
			default: begin
				res = pos_kr;
			end
		endcase
		return res;
	endfunction

endpackage

>>> rtl/rrbb_front.sv
// ----------------------------------------------------------------------------
// Rotated rectangle bounding box: front stage
// Looks up cosine and sine and forms the corner offsets from the center.
// ----------------------------------------------------------------------------
module rrbb_front #(
	parameter int COORD_BITS = rrbb_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        rect_x,
	input  logic signed [COORD_BITS-1:0]        rect_y,
	input  logic        [COORD_BITS-2:0]        rect_w,
	input  logic        [COORD_BITS-2:0]        rect_h,
	input  logic signed [COORD_BITS-1:0]        center_x,
	input  logic signed [COORD_BITS-1:0]        center_y,
	input  logic        [rrbb_pkg::ANGLE_BITS-1:0] angle,
	output logic                                v_s1,
	input  logic                                take_s2,
	output logic signed [COORD_BITS+1:0]        dx0_s1,
	output logic signed [COORD_BITS+1:0]        dx1_s1,
	output logic signed [COORD_BITS+1:0]        dy0_s1,
	output logic signed [COORD_BITS+1:0]        dy1_s1,
	output logic signed [rrbb_pkg::TRIG_BITS-1:0] cos_s1,
	output logic signed [rrbb_pkg::TRIG_BITS-1:0] sin_s1,
	output logic signed [COORD_BITS-1:0]        cx_s1,
	output logic signed [COORD_BITS-1:0]        cy_s1
);

	localparam int DW = COORD_BITS + 2;

	logic signed [DW-1:0] xe;
	logic signed [DW-1:0] ye;
	logic signed [DW-1:0] we;
	logic signed [DW-1:0] he;
	logic signed [DW-1:0] cxe;
	logic signed [DW-1:0] cye;
	logic                 take_s1;

	assign xe  = DW'(rect_x);
	assign ye  = DW'(rect_y);
	assign we  = DW'({1'b0, rect_w});
	assign he  = DW'({1'b0, rect_h});
	assign cxe = DW'(center_x);
	assign cye = DW'(center_y);

	assign take_s1  = !v_s1 || take_s2;
	assign in_ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) begin
			dx0_s1 <= xe - cxe;
			dx1_s1 <= xe + we - cxe;
			dy0_s1 <= ye - cye;
			dy1_s1 <= ye + he - cye;
			cos_s1 <= rrbb_pkg::cos_q8(angle);
			sin_s1 <= rrbb_pkg::cos_q8(angle - rrbb_pkg::ANGLE_BITS'(rrbb_pkg::QUARTER));
			cx_s1  <= center_x;
			cy_s1  <= center_y;
		end
	end

endmodule

>>> rtl/rrbb_rotate.sv
// ----------------------------------------------------------------------------
// Rotated rectangle bounding box: rotation stages
// Multiplies the offsets by cosine and sine, then forms the four corners.
// ----------------------------------------------------------------------------
module rrbb_rotate #(
	parameter int COORD_BITS = rrbb_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  v_s1,
	output logic                                  take_s2,
	input  logic signed [COORD_BITS+1:0]          dx0_s1,
	input  logic signed [COORD_BITS+1:0]          dx1_s1,
	input  logic signed [COORD_BITS+1:0]          dy0_s1,
	input  logic signed [COORD_BITS+1:0]          dy1_s1,
	input  logic signed [rrbb_pkg::TRIG_BITS-1:0] cos_s1,
	input  logic signed [rrbb_pkg::TRIG_BITS-1:0] sin_s1,
	input  logic signed [COORD_BITS-1:0]          cx_s1,
	input  logic signed [COORD_BITS-1:0]          cy_s1,
	output logic                                  v_s3,
	input  logic                                  take_s4,
	output logic signed [COORD_BITS+5:0]          x_s3 [4],
	output logic signed [COORD_BITS+5:0]          y_s3 [4]
);

	localparam int DW = COORD_BITS + 2;
	localparam int PW = DW + rrbb_pkg::TRIG_BITS;
	localparam int SW = PW + 1;
	localparam int RW = COORD_BITS + 6;

	logic signed [PW-1:0]         pxc_s2 [2];
	logic signed [PW-1:0]         pxs_s2 [2];
	logic signed [PW-1:0]         pyc_s2 [2];
	logic signed [PW-1:0]         pys_s2 [2];
	logic signed [COORD_BITS-1:0] cx_s2;
	logic signed [COORD_BITS-1:0] cy_s2;
	logic                         v_s2;
	logic                         take_s3;
	logic signed [SW-1:0]         sx [4];
	logic signed [SW-1:0]         sy [4];
	logic signed [RW-1:0]         xn [4];
	logic signed [RW-1:0]         yn [4];

	assign take_s3 = !v_s3 || take_s4;
	assign take_s2 = !v_s2 || take_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			if (take_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && v_s1) begin
			pxc_s2[0] <= PW'(dx0_s1) * PW'(cos_s1);
			pxc_s2[1] <= PW'(dx1_s1) * PW'(cos_s1);
			pxs_s2[0] <= PW'(dx0_s1) * PW'(sin_s1);
			pxs_s2[1] <= PW'(dx1_s1) * PW'(sin_s1);
			pyc_s2[0] <= PW'(dy0_s1) * PW'(cos_s1);
			pyc_s2[1] <= PW'(dy1_s1) * PW'(cos_s1);
			pys_s2[0] <= PW'(dy0_s1) * PW'(sin_s1);
			pys_s2[1] <= PW'(dy1_s1) * PW'(sin_s1);
			cx_s2     <= cx_s1;
			cy_s2     <= cy_s1;
		end
	end

	// Corner order: origin, right of origin, below origin, opposite corner.
	always_comb begin
		sx[0] = SW'(pxc_s2[0]) + SW'(pys_s2[0]);
		sx[1] = SW'(pxc_s2[1]) + SW'(pys_s2[0]);
		sx[2] = SW'(pxc_s2[0]) + SW'(pys_s2[1]);
		sx[3] = SW'(pxc_s2[1]) + SW'(pys_s2[1]);
		sy[0] = SW'(pyc_s2[0]) - SW'(pxs_s2[0]);
		sy[1] = SW'(pyc_s2[0]) - SW'(pxs_s2[1]);
		sy[2] = SW'(pyc_s2[1]) - SW'(pxs_s2[0]);
		sy[3] = SW'(pyc_s2[1]) - SW'(pxs_s2[1]);
		for (int i = 0; i < 4; i++) begin
			xn[i] = RW'(sx[i] >>> rrbb_pkg::Q8_SHIFT) + RW'(cx_s2);
			yn[i] = RW'(sy[i] >>> rrbb_pkg::Q8_SHIFT) + RW'(cy_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3 && v_s2) begin
			x_s3 <= xn;
			y_s3 <= yn;
		end
	end

endmodule

>>> rtl/rrbb_extent.sv
// ----------------------------------------------------------------------------
// Rotated rectangle bounding box: extent stages
// Finds the corner extremes and forms the box origin and spans.
// ----------------------------------------------------------------------------
module rrbb_extent #(
	parameter int COORD_BITS = rrbb_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 v_s3,
	output logic                                 take_s4,
	input  logic signed [COORD_BITS+5:0]         x_s3 [4],
	input  logic signed [COORD_BITS+5:0]         y_s3 [4],
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [rrbb_pkg::OUT_BITS-1:0] box_x,
	output logic signed [rrbb_pkg::OUT_BITS-1:0] box_y,
	output logic        [rrbb_pkg::OUT_BITS-1:0] box_w,
	output logic        [rrbb_pkg::OUT_BITS-1:0] box_h
);

	localparam int RW = COORD_BITS + 6;
	localparam int OW = rrbb_pkg::OUT_BITS;
	localparam int XW = (RW > OW) ? RW : OW;

	logic signed [RW-1:0] mnx_a, mnx_b, mxx_a, mxx_b;
	logic signed [RW-1:0] mny_a, mny_b, mxy_a, mxy_b;
	logic signed [RW-1:0] minx_s4, maxx_s4, miny_s4, maxy_s4;
	logic                 v_s4;
	logic                 v_s5;
	logic                 take_s5;
	logic        [RW-1:0] spanx;
	logic        [RW-1:0] spany;
	logic signed [XW-1:0] minx_ext;
	logic signed [XW-1:0] miny_ext;
	logic        [XW-1:0] spanx_ext;
	logic        [XW-1:0] spany_ext;

	assign take_s5 = !v_s5 || out_ready;
	assign take_s4 = !v_s4 || take_s5;
	assign out_valid = v_s5;

	always_comb begin
		mnx_a = (x_s3[0] < x_s3[1]) ? x_s3[0] : x_s3[1];
		mnx_b = (x_s3[2] < x_s3[3]) ? x_s3[2] : x_s3[3];
		mxx_a = (x_s3[0] > x_s3[1]) ? x_s3[0] : x_s3[1];
		mxx_b = (x_s3[2] > x_s3[3]) ? x_s3[2] : x_s3[3];
		mny_a = (y_s3[0] < y_s3[1]) ? y_s3[0] : y_s3[1];
		mny_b = (y_s3[2] < y_s3[3]) ? y_s3[2] : y_s3[3];
		mxy_a = (y_s3[0] > y_s3[1]) ? y_s3[0] : y_s3[1];
		mxy_b = (y_s3[2] > y_s3[3]) ? y_s3[2] : y_s3[3];
	end

	assign spanx     = maxx_s4 - minx_s4;
	assign spany     = maxy_s4 - miny_s4;
	assign minx_ext  = XW'(minx_s4);
	assign miny_ext  = XW'(miny_s4);
	assign spanx_ext = XW'(spanx);
	assign spany_ext = XW'(spany);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (take_s4) begin
				v_s4 <= v_s3;
			end
			if (take_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s4 && v_s3) begin
			minx_s4 <= (mnx_a < mnx_b) ? mnx_a : mnx_b;
			maxx_s4 <= (mxx_a > mxx_b) ? mxx_a : mxx_b;
			miny_s4 <= (mny_a < mny_b) ? mny_a : mny_b;
			maxy_s4 <= (mxy_a > mxy_b) ? mxy_a : mxy_b;
		end
		if (take_s5 && v_s4) begin
			box_x <= minx_ext[OW-1:0];
			box_y <= miny_ext[OW-1:0];
			box_w <= spanx_ext[OW-1:0];
			box_h <= spany_ext[OW-1:0];
		end
	end

endmodule

>>> rtl/rotated_rect_bounding_box_top.sv
// Path: an input transfer is registered in stages s1 through s5 before its result reaches the output.
// Throughput: one rectangle per cycle unless out_ready stalls the output; each of the five stages holds one item.
// The eight offset-by-trig products sit in their own stage, one multiplier each.
// Ready passes back combinationally through all stages, so empty stages keep filling.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// Rotated rectangle bounding box: top level
// Rotates the four corners of a rectangle about a center and returns the
// axis-aligned box that encloses them.
// ----------------------------------------------------------------------------
module rotated_rect_bounding_box_top #(
	parameter int COORD_BITS = rrbb_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [COORD_BITS-1:0]           rect_x,
	input  logic signed [COORD_BITS-1:0]           rect_y,
	input  logic        [COORD_BITS-2:0]           rect_w,
	input  logic        [COORD_BITS-2:0]           rect_h,
	input  logic signed [COORD_BITS-1:0]           center_x,
	input  logic signed [COORD_BITS-1:0]           center_y,
	input  logic        [rrbb_pkg::ANGLE_BITS-1:0] angle,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rrbb_pkg::OUT_BITS-1:0]   box_x,
	output logic signed [rrbb_pkg::OUT_BITS-1:0]   box_y,
	output logic        [rrbb_pkg::OUT_BITS-1:0]   box_w,
	output logic        [rrbb_pkg::OUT_BITS-1:0]   box_h
);

	logic                                  v_s1;
	logic                                  take_s2;
	logic signed [COORD_BITS+1:0]          dx0_s1, dx1_s1, dy0_s1, dy1_s1;
	logic signed [rrbb_pkg::TRIG_BITS-1:0] cos_s1, sin_s1;
	logic signed [COORD_BITS-1:0]          cx_s1, cy_s1;
	logic                                  v_s3;
	logic                                  take_s4;
	logic signed [COORD_BITS+5:0]          x_s3 [4];
	logic signed [COORD_BITS+5:0]          y_s3 [4];

	rrbb_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rect_x   (rect_x),
		.rect_y   (rect_y),
		.rect_w   (rect_w),
		.rect_h   (rect_h),
		.center_x (center_x),
		.center_y (center_y),
		.angle    (angle),
		.v_s1     (v_s1),
		.take_s2  (take_s2),
		.dx0_s1   (dx0_s1),
		.dx1_s1   (dx1_s1),
		.dy0_s1   (dy0_s1),
		.dy1_s1   (dy1_s1),
		.cos_s1   (cos_s1),
		.sin_s1   (sin_s1),
		.cx_s1    (cx_s1),
		.cy_s1    (cy_s1)
	);

	rrbb_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s1    (v_s1),
		.take_s2 (take_s2),
		.dx0_s1  (dx0_s1),
		.dx1_s1  (dx1_s1),
		.dy0_s1  (dy0_s1),
		.dy1_s1  (dy1_s1),
		.cos_s1  (cos_s1),
		.sin_s1  (sin_s1),
		.cx_s1   (cx_s1),
		.cy_s1   (cy_s1),
		.v_s3    (v_s3),
		.take_s4 (take_s4),
		.x_s3    (x_s3),
		.y_s3    (y_s3)
	);

	rrbb_extent #(.COORD_BITS(COORD_BITS)) u_extent (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s3      (v_s3),
		.take_s4   (take_s4),
		.x_s3      (x_s3),
		.y_s3      (y_s3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.box_x     (box_x),
		.box_y     (box_y),
		.box_w     (box_w),
		.box_h     (box_h)
	);

endmodule

>>> rtl/rrbb_checker.sv
// ----------------------------------------------------------------------------
// Rotated rectangle bounding box: port checker
// Watches the top-level ports for output hold, flow and identity behavior.
// ----------------------------------------------------------------------------
module rrbb_checker #(
	parameter int COORD_BITS = rrbb_pkg::COORD_BITS_DEF
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic        [COORD_BITS-2:0]           rect_w,
	input logic        [COORD_BITS-2:0]           rect_h,
	input logic        [rrbb_pkg::ANGLE_BITS-1:0] angle,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [rrbb_pkg::OUT_BITS-1:0]   box_x,
	input logic signed [rrbb_pkg::OUT_BITS-1:0]   box_y,
	input logic        [rrbb_pkg::OUT_BITS-1:0]   box_w,
	input logic        [rrbb_pkg::OUT_BITS-1:0]   box_h
);

	localparam int OW = rrbb_pkg::OUT_BITS;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(box_x) && $stable(box_y)
			&& $stable(box_w) && $stable(box_h))
		else $error("result changed while stalled");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output accepts");

	// With a zero angle and no stall, the box width and height equal those of the unrotated rectangle.
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && angle == '0 && out_ready) ##1 out_ready ##1 out_ready
			##1 out_ready ##1 out_ready
		|=> out_valid && box_w == OW'($past(rect_w, 5)) && box_h == OW'($past(rect_h, 5)))
		else $error("zero-angle box does not match the rectangle size");

endmodule

bind rotated_rect_bounding_box_top rrbb_checker #(.COORD_BITS(COORD_BITS)) u_rrbb_checker (.*);
